/* src/scancode_ascii_fifo_macros.svh */
// Assertion macros shared by the scancode FIFO modules.
// No dependencies; included by the files that carry assertions.
`ifndef SCANCODE_ASCII_FIFO_MACROS_SVH
`define SCANCODE_ASCII_FIFO_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define SCAF_ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SCAF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/scaf_pkg.sv */
// Types, constants and the set-1 scancode to ASCII lookup for the scancode FIFO.
// No dependencies.
package scaf_pkg;

    localparam int ACT_W  = 2;
    localparam int CODE_W = 8;
    localparam int CHAR_W = 8;
    localparam int FILL_W = 11;

    localparam logic [CHAR_W-1:0] CHAR_UNKNOWN = 8'h3F;
    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;

    typedef enum logic [ACT_W-1:0] {
        ACT_KEY   = 2'd0,
        ACT_READ  = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
    } t_cmd;

    function automatic logic [CHAR_W-1:0] to_ascii(input logic [CODE_W-2:0] code);
        logic [CHAR_W-1:0] ch;
        unique case (code)
            7'h02: ch = 8'h31;
            7'h03: ch = 8'h32;
            7'h04: ch = 8'h33;
            7'h05: ch = 8'h34;
            7'h06: ch = 8'h35;
            7'h07: ch = 8'h36;
            7'h08: ch = 8'h37;
            7'h09: ch = 8'h38;
            7'h0A: ch = 8'h39;
            7'h0B: ch = 8'h30;
            7'h10: ch = 8'h71;
            7'h11: ch = 8'h77;
            7'h12: ch = 8'h65;
            7'h13: ch = 8'h72;
            7'h14: ch = 8'h74;
            7'h15: ch = 8'h79;
            7'h16: ch = 8'h75;
            7'h17: ch = 8'h69;
            7'h18: ch = 8'h6F;
            7'h19: ch = 8'h70;
            7'h1E: ch = 8'h61;
            7'h1F: ch = 8'h73;
            7'h20: ch = 8'h64;
            7'h21: ch = 8'h66;
            7'h22: ch = 8'h67;
            7'h23: ch = 8'h68;
            7'h24: ch = 8'h6A;
            7'h25: ch = 8'h6B;
            7'h26: ch = 8'h6C;
            7'h2C: ch = 8'h7A;
            7'h2D: ch = 8'h78;
            7'h2E: ch = 8'h63;
            7'h2F: ch = 8'h76;
            7'h30: ch = 8'h62;
            7'h31: ch = 8'h6E;
            7'h32: ch = 8'h6D;
            7'h39: ch = CHAR_SPACE;
            7'h1C: ch = CHAR_NEWLINE;
            default: ch = CHAR_UNKNOWN;
        endcase
        return ch;
    endfunction

endpackage

/* src/scancode_ascii_fifo.sv */
// Top level of the scancode FIFO: set-1 scancodes to ASCII into a ring buffer.
// Depends on scaf_pkg, scaf_ctrl and scaf_dpath.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one item: i_action selects
//   a key event (i_scancode), a read of one character, or a buffer clear.
//   Output channel (o_out_valid / i_out_ready) returns exactly one result per
//   item: o_char_out / o_char_valid for reads, o_dropped when a press finds
//   the buffer full, and o_fill_level, the count after the item.
//   Each item runs through the load / execute / respond sequence of the
//   controller: the item registers capture it at load, the execute step
//   updates the buffer with the registered read of the character store and
//   registers the result, and the respond step presents it.
//   A new item is taken only after the previous result has been accepted;
//   while the receiver stalls, the result holds and o_in_ready stays low.
//   Reset (i_rst_n low, synchronous) empties the buffer and returns the
//   controller to idle; the character store itself is not cleared.
module scancode_ascii_fifo
    import scaf_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [ACT_W-1:0]  i_action,
    input  logic [CODE_W-1:0] i_scancode,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [CHAR_W-1:0] o_char_out,
    output logic              o_char_valid,
    output logic              o_dropped,
    output logic [FILL_W-1:0] o_fill_level
);

    t_cmd cmd;

    scaf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    scaf_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_action     (i_action),
        .i_scancode   (i_scancode),
        .o_char_out   (o_char_out),
        .o_char_valid (o_char_valid),
        .o_dropped    (o_dropped),
        .o_fill_level (o_fill_level)
    );

endmodule

/* src/scaf_ctrl.sv */
// Handshake controller for the scancode FIFO: load, execute, respond.
// Depends on scaf_pkg and scancode_ascii_fifo_macros.svh.
`include "scancode_ascii_fifo_macros.svh"

module scaf_ctrl
    import scaf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_out_ready,
    output logic o_in_ready,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = ST_RESP;
            end
            ST_RESP: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    `SCAF_ASSERT_NEXT(a_load_then_exec, i_clk, i_rst_n, o_cmd.load, o_cmd.exec, "exec did not follow load")
    `SCAF_ASSERT_NEXT(a_exec_then_resp, i_clk, i_rst_n, o_cmd.exec, o_out_valid, "no result after exec")

endmodule

/* src/scaf_dpath.sv */
// Datapath of the scancode FIFO: item registers, character store, pointers, count.
// Depends on scaf_pkg and scancode_ascii_fifo_macros.svh.
`include "scancode_ascii_fifo_macros.svh"

module scaf_dpath
    import scaf_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [ACT_W-1:0]  i_action,
    input  logic [CODE_W-1:0] i_scancode,
    output logic [CHAR_W-1:0] o_char_out,
    output logic              o_char_valid,
    output logic              o_dropped,
    output logic [FILL_W-1:0] o_fill_level
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [CHAR_W-1:0] mem [DEPTH];

    t_action           r_action;
    logic [CODE_W-1:0] r_code;
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic [CHAR_W-1:0] r_rd_data;
    logic              r_char_valid;
    logic              r_dropped;

    logic press;
    logic full;
    logic empty;
    logic push;
    logic pop;
    logic clear;

    assign press = (r_action == ACT_KEY) && !r_code[CODE_W-1];
    assign full  = (r_count == CNT_FULL);
    assign empty = (r_count == '0);
    assign push  = i_cmd.exec && press && !full;
    assign pop   = i_cmd.exec && (r_action == ACT_READ) && !empty;
    assign clear = i_cmd.exec && (r_action == ACT_CLEAR);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= t_action'(i_action);
            r_code   <= i_scancode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            mem[r_wr_ptr] <= to_ascii(r_code[CODE_W-2:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_rd_data <= mem[r_rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_count      <= '0;
            r_char_valid <= 1'b0;
            r_dropped    <= 1'b0;
        end else if (i_cmd.exec) begin
            r_char_valid <= pop;
            r_dropped    <= press && full;
            if (clear) begin
                r_wr_ptr <= '0;
                r_rd_ptr <= '0;
                r_count  <= '0;
            end else if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
                r_count  <= r_count + 1'b1;
            end else if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
                r_count  <= r_count - 1'b1;
            end
        end
    end

    assign o_char_out   = r_char_valid ? r_rd_data : '0;
    assign o_char_valid = r_char_valid;
    assign o_dropped    = r_dropped;
    assign o_fill_level = FILL_W'(r_count);

    `SCAF_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CNT_FULL, "count above depth")
    `SCAF_ASSERT_ALWAYS(a_ptr_match, i_clk, i_rst_n, (r_wr_ptr == r_rd_ptr) == (empty || full), "pointers disagree with count")
    `SCAF_ASSERT_ALWAYS(a_flags_excl, i_clk, i_rst_n, !(r_char_valid && r_dropped), "read and drop in one item")

endmodule
